>>> design/seq_pkg.sv
// Shared types and constants for the sorted event queue.
// Holds field widths, command codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package seq_pkg;

    localparam int KEY_W         = 32;
    localparam int COUNT_OUT_W   = 5;
    localparam int DEFAULT_DEPTH = 16;
    localparam int M_TDATA_W     = 40;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic rd;
        logic ins_shift;
        logic ins_place;
        logic rem_pop;
        logic rem_move;
        logic rem_finish;
        logic set_full;
        logic set_empty;
        logic emit;
    } seq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_insert;
        logic occ_full;
        logic occ_zero;
        logic pos_zero;
        logic pos_at_end;
        logic rd_gt_key;
        logic out_free;
    } seq_stat_t;

endpackage

`default_nettype wire

>>> design/sorted_event_queue_core.sv
// Sorted event queue: ordered store of 16.16 departure times with insert and pop-smallest.
// Top level joining seq_ctrl and seq_dpath; depends on seq_pkg.
//
// Usage:
//   Input beats on s_*: s_tuser is the command (0 insert, 1 remove), s_tdata the time key.
//   Every input beat gives exactly one result beat on m_*, in order.
//   Keys are kept ascending in a single-port memory; equal keys leave first in, first out.
//   An insert walks down from the tail, reading each held key and moving it up one slot
//   while it is larger than the new one; the new key goes in above the first key that is
//   not larger, or into the bottom slot when every held key is larger. A remove returns
//   the head and moves each remaining key down one slot. A dropped insert or a remove
//   from an empty queue goes straight to its result without touching the memory.
//   One item is worked on at a time; s_tready is high only while the block is idle, so
//   the next beat can be taken in the cycle after the result is registered.
//   Insert into a full queue sets was_full and drops the key; remove from an empty queue
//   sets was_empty and returns zero. entry_count is the occupancy after the item.
//   A stalled result is held in the output register; the block takes the next input beat
//   while that result waits, and stalls only when a second result is ready.
//   Reset empties the queue at once (no clearing pass); stale memory is never read.
`default_nettype none

module sorted_event_queue_core
    import seq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [KEY_W-1:0]       s_tdata,   // [31:0] time_key
    input  wire logic                   s_tuser,   // [0] command
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata    // [31:0] removed_time, [32] was_empty,
                                                   // [33] was_full, [38:34] entry_count
);

    seq_cmd_t  cmd;
    seq_stat_t stat;

    seq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    seq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

>>> design/seq_ctrl.sv
// Controller state machine for the sorted event queue.
// Sequences insert and remove walks over the key memory; depends on seq_pkg.
`default_nettype none

module seq_ctrl
    import seq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire seq_stat_t stat,
    output seq_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_INS_CMP  = 7'b0000100,
        ST_REM_POP  = 7'b0001000,
        ST_REM_NEXT = 7'b0010000,
        ST_REM_MOVE = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.is_insert) begin
                    if (stat.occ_full) begin
                        cmd.set_full = 1'b1;
                        state_next   = ST_DONE;
                    end else if (stat.pos_zero) begin
                        cmd.ins_place = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        cmd.rd     = 1'b1;
                        state_next = ST_INS_CMP;
                    end
                end else begin
                    if (stat.occ_zero) begin
                        cmd.set_empty = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        cmd.rd     = 1'b1;
                        state_next = ST_REM_POP;
                    end
                end
            end
            ST_INS_CMP: begin
                // larger keys move up one slot; stop at the first key not larger
                if (stat.rd_gt_key) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_DISPATCH;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_REM_POP: begin
                cmd.rem_pop = 1'b1;
                state_next  = ST_REM_NEXT;
            end
            ST_REM_NEXT: begin
                if (stat.pos_at_end) begin
                    cmd.rem_finish = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_REM_MOVE;
                end
            end
            ST_REM_MOVE: begin
                cmd.rem_move = 1'b1;
                state_next   = ST_REM_NEXT;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/seq_dpath.sv
// Datapath for the sorted event queue: key memory, walk pointer, occupancy and result register.
// Driven by seq_ctrl through seq_cmd_t; depends on seq_pkg.
`default_nettype none

module seq_dpath
    import seq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [KEY_W-1:0]     s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire seq_cmd_t             cmd,
    output seq_stat_t                 stat
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [KEY_W-1:0] key_mem [QUEUE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [KEY_W-1:0] popped_reg;
    logic             empty_reg;
    logic             full_reg;

    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    logic [CNT_W-1:0]       pos_m1;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_W-1:0]       wr_data;
    logic                   wr_en;
    logic [CNT_W+COUNT_OUT_W-1:0] occ_ext;

    assign pos_m1  = pos_reg - CNT_W'(1);
    assign rd_addr = (cmd_reg == CMD_INSERT) ? pos_m1[IDX_W-1:0] : pos_reg[IDX_W-1:0];
    assign wr_addr = cmd.rem_move ? pos_m1[IDX_W-1:0] : pos_reg[IDX_W-1:0];
    assign wr_data = cmd.ins_place ? key_reg : rd_data_reg;
    assign wr_en   = cmd.ins_shift | cmd.ins_place | cmd.rem_move;
    assign occ_ext = {{COUNT_OUT_W{1'b0}}, occ_reg};

    // Single-port style key store: one write or one registered read per cycle, never both
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // Item registers and walk pointer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= s_tuser;
            key_reg    <= s_tdata;
            pos_reg    <= (s_tuser == CMD_INSERT) ? occ_reg : '0;
            popped_reg <= '0;
            empty_reg  <= 1'b0;
            full_reg   <= 1'b0;
        end else begin
            if (cmd.ins_shift) begin
                pos_reg <= pos_m1;
            end
            if (cmd.rem_pop) begin
                popped_reg <= rd_data_reg;
                pos_reg    <= pos_reg + CNT_W'(1);
            end
            if (cmd.rem_move) begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
            if (cmd.set_full) begin
                full_reg <= 1'b1;
            end
            if (cmd.set_empty) begin
                empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.ins_place) begin
            occ_reg <= occ_reg + CNT_W'(1);
        end else if (cmd.rem_finish) begin
            occ_reg <= occ_reg - CNT_W'(1);
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {1'b0, occ_ext[COUNT_OUT_W-1:0], full_reg, empty_reg, popped_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign stat.is_insert  = (cmd_reg == CMD_INSERT);
    assign stat.occ_full   = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.occ_zero   = (occ_reg == '0);
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.pos_at_end = (pos_reg == occ_reg);
    assign stat.rd_gt_key  = (rd_data_reg > key_reg);
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

>>> design/seq_checker.sv
// Port-level checks for sorted_event_queue_core, attached by bind.
// Depends on seq_pkg for field widths.
`default_nettype none

module seq_checker
    import seq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("empty and full flagged together");

    a_flag_zero_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[32] || m_tdata[33]) |-> m_tdata[31:0] == '0)
        else $error("flagged beat carries a time");

    // s_tready drops once an item is accepted, so no second item is taken while one is in work
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

bind sorted_event_queue_core seq_checker u_seq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_sorted_event_queue_core.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_event_queue_core: random insert/remove traffic with ties,
// full and empty cases, checked beat by beat against an ordered-queue predictor in a class.
// Depends on seq_pkg and sorted_event_queue_core.

module tb_sorted_event_queue_core
    import seq_pkg::*;
();

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 630;
    localparam int TAIL_CYCLES  = 4 + 2 * DEPTH;

    // Predicts each result beat from the accepted commands and checks the beats that come back
    class departure_queue_model;
        typedef struct packed {
            logic [KEY_W-1:0]       removed_time;
            logic                   was_empty;
            logic                   was_full;
            logic [COUNT_OUT_W-1:0] entry_count;
        } result_t;

        int unsigned      capacity;
        logic [KEY_W-1:0] held_keys[$];
        result_t          due[$];
        int unsigned      failures, checked, inserts, removes, drops, empty_pops;

        function new(int unsigned depth);
            capacity   = depth;
            failures   = 0;
            checked    = 0;
            inserts    = 0;
            removes    = 0;
            drops      = 0;
            empty_pops = 0;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function void note_item(logic cmd, logic [KEY_W-1:0] key);
            result_t     r;
            int unsigned slot;
            r = '0;
            if (cmd == CMD_INSERT) begin
                inserts++;
                if (held_keys.size() >= capacity) begin
                    r.was_full = 1'b1;
                    drops++;
                end else begin
                    // place after every held key that is less than or equal: ties stay FIFO
                    slot = 0;
                    while (slot < held_keys.size() && held_keys[slot] <= key)
                        slot++;
                    held_keys.insert(slot, key);
                end
            end else begin
                removes++;
                if (held_keys.size() == 0) begin
                    r.was_empty = 1'b1;
                    empty_pops++;
                end else begin
                    r.removed_time = held_keys.pop_front();
                end
            end
            r.entry_count = COUNT_OUT_W'(held_keys.size());
            due.push_back(r);
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] beat);
            result_t got, want;
            got.removed_time = beat[KEY_W-1:0];
            got.was_empty    = beat[KEY_W];
            got.was_full     = beat[KEY_W+1];
            got.entry_count  = beat[KEY_W+2 +: COUNT_OUT_W];
            checked++;
            if (due.size() == 0) begin
                if (failures < 10)
                    $display("%0t: result beat with nothing outstanding: %h", $time, beat);
                failures++;
                return;
            end
            want = due.pop_front();
            if (got.removed_time !== want.removed_time || got.was_empty !== want.was_empty ||
                    got.was_full !== want.was_full || got.entry_count !== want.entry_count) begin
                if (failures < 10) begin
                    $display("%0t: beat %0d mismatch (exp/act)", $time, checked);
                    $display("    time %h/%h empty %b/%b full %b/%b count %0d/%0d",
                             want.removed_time, got.removed_time,
                             want.was_empty, got.was_empty, want.was_full, got.was_full,
                             want.entry_count, got.entry_count);
                end
                failures++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [KEY_W-1:0]       s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    departure_queue_model   board;
    bit                     tx_idle;
    bit                     rx_idle;
    logic [KEY_W-1:0]       tie_pool[4];

    sorted_event_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offer one beat (after a random gap when tx_idle is set), hold it until taken, then log it with the predictor
    task automatic send(input logic cmd, input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_item(cmd, key);
    endtask

    // Drop tvalid so the last beat is not taken twice, then wait for every result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return tie_pool[$urandom_range(0, 3)];
            7: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            // small whole-number times land close together and often collide
            default: return {16'($urandom_range(0, 7)), 16'h0000};
        endcase
    endfunction

    // Result side: when rx_idle is set, stall for a random count before each beat
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            board.check_beat(m_tdata);
        end
    end

    initial begin
        int unsigned sent, phase_no, phase_len, insert_pct;
        logic        cmd;
        board    = new(DEPTH);
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_INSERT;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn  <= 1'b1;

        // Directed: empty pop, extreme keys, ties at bottom, middle and top, drain to empty
        send(CMD_REMOVE, $urandom());
        send(CMD_INSERT, 32'hFFFF_FFFF);
        send(CMD_INSERT, 32'h0000_0000);
        send(CMD_INSERT, 32'h0001_0000);
        send(CMD_INSERT, 32'h0001_0000);
        send(CMD_INSERT, 32'h8000_0000);
        send(CMD_INSERT, 32'hFFFF_FFFF);
        send(CMD_INSERT, 32'h0000_0000);
        send(CMD_INSERT, 32'h5555_AAAA);
        send(CMD_INSERT, 32'hAAAA_5555);
        repeat (9) send(CMD_REMOVE, $urandom());
        send(CMD_REMOVE, 32'hFFFF_FFFF);
        wait_drained();

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            // open with a fill past capacity and a drain past empty, then mix
            if (phase_no == 0) begin
                phase_len  = DEPTH + 4;
                insert_pct = 100;
            end else if (phase_no == 1) begin
                phase_len  = DEPTH + 4;
                insert_pct = 0;
            end else begin
                phase_len = $urandom_range(15, 60);
                case ($urandom_range(0, 3))
                    0: insert_pct = 85;
                    1: insert_pct = 20;
                    2: insert_pct = 50;
                    default: insert_pct = 65;
                endcase
            end
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
            foreach (tie_pool[i])
                tie_pool[i] = $urandom();
            repeat (phase_len) begin
                cmd = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_REMOVE;
                send(cmd, pick_key());
                sent++;
            end
            if (phase_no == 1 || $urandom_range(0, 3) == 0)
                wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d inserts (%0d dropped at capacity) and %0d removes (%0d on empty queue)",
                 board.inserts, board.drops, board.removes, board.empty_pops);
        $display("Checked %0d result beats over %0d traffic phases with random stalls on both sides",
                 board.checked, phase_no);
        if (board.failures == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", board.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
